@@ sv/srw_pkg.sv @@
// Shared types, codes and character helpers for the S-record writer.
// No dependencies; imported by srecord_s1_record_writer.
package srw_pkg;

  // Item kinds carried on in_tuser[1:0]
  typedef enum logic [1:0] {
    MODE_DATA   = 2'd0,
    MODE_ORIGIN = 2'd1,
    MODE_END    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef logic [6:0] char_t;

  localparam char_t CH_S  = 7'h53;
  localparam char_t CH_1  = 7'h31;
  localparam char_t CH_9  = 7'h39;
  localparam char_t CH_0  = 7'h30;
  localparam char_t CH_A  = 7'h41;

  // Fixed byte count of an end record (two address bytes plus checksum)
  localparam logic [7:0] END_LEN = 8'd3;
  localparam logic [7:0] HDR_LEN = 8'd3;

  // Upper-case ASCII hex digit for a nibble
  function automatic char_t hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = CH_0 + char_t'(nib);
    end else begin
      hex_char = CH_A + char_t'(nib - 4'd10);
    end
  endfunction

endpackage

@@ sv/srw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the record byte buffer.
module srw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/srecord_s1_record_writer.sv @@
// Top level of the S-record writer: input decode, record state and pair sequencer.
// Depends on srw_pkg and srw_ram.
// Usage:
//   Input words arrive on in_tvalid/in_tready/in_tdata/in_tuser. in_tuser[1:0]
//   is the kind (data, origin, end), in_tuser[2] says the data is a 16-bit word.
//   Data bytes fill a record buffer of RECORD_BYTES entries held in a RAM.
//   Output words are character pairs of ASCII hex S-records; out_tlast marks the
//   checksum pair that ends a record.
// Timing:
//   A data byte is written in ST_IDLE, a word's high byte in ST_BYTE2. A full buffer,
//   an origin item or an end item starts a record: one pair per cycle unless stalled,
//   4 + fill + 1 pairs for S1 and 5 for S9, set by the pair sequencer. The first
//   pair is registered in ST_HEAD, after ST_IDLE or, when a word's high byte fills
//   the buffer, ST_BYTE2. in_tready is high only while no item is in progress.
// Reset:
//   rst_n (synchronous, active low) empties the buffer, zeroes the sum and the
//   record address and drops out_tvalid. Buffer contents are not cleared.
// Stalls:
//   The output register holds a pair until out_tready; the sequencer waits
//   behind it and no pair is lost or repeated.
module srecord_s1_record_writer #(
  parameter int RECORD_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] datum, [31:16] location
  input  logic [2:0]  in_tuser,   // [1:0] mode, [2] is_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] char_first, [13:7] char_second, [15:14] zero
  output logic        out_tlast
);
  import srw_pkg::*;

  localparam int IDXW  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int FILLW = $clog2(RECORD_BYTES + 1);
  localparam logic [FILLW-1:0] FULL = FILLW'(RECORD_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE2,
    ST_HEAD,
    ST_LEN,
    ST_AHI,
    ST_ALO,
    ST_DATA,
    ST_SUM
  } state_t;

  state_t           state_r, state_nxt;
  logic [FILLW-1:0] fill_r, fill_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [15:0]      loc_r, loc_nxt;
  logic [15:0]      next_addr_r, next_addr_nxt;
  logic [7:0]       hi_byte_r, hi_byte_nxt;
  logic             hi_pend_r, hi_pend_nxt;
  logic             is_end_r, is_end_nxt;
  logic [IDXW-1:0]  idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  char_t            out_c1_r, out_c1_nxt;
  char_t            out_c2_r, out_c2_nxt;
  logic             out_last_r, out_last_nxt;

  logic             ram_we;
  logic [IDXW-1:0]  ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  logic             in_fire;
  logic             out_free;
  mode_t            in_mode;
  logic [7:0]       len_byte;
  logic [15:0]      hdr_addr;
  logic [7:0]       chk_sum;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_mode  = mode_t'(in_tuser[1:0]);
  assign len_byte = is_end_r ? END_LEN : (8'(fill_r) + HDR_LEN);
  assign hdr_addr = is_end_r ? loc_r : addr_r;
  assign chk_sum  = is_end_r ? ~(END_LEN + loc_r[15:8] + loc_r[7:0])
                             : ~(sum_r + len_byte);

  // Record byte buffer
  srw_ram #(
    .WIDTH (8),
    .DEPTH (RECORD_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_nxt),
    .rdata (ram_rdata)
  );

  // Sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    addr_nxt      = addr_r;
    loc_nxt       = loc_r;
    next_addr_nxt = next_addr_r;
    hi_byte_nxt   = hi_byte_r;
    hi_pend_nxt   = hi_pend_r;
    is_end_nxt    = is_end_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_c1_nxt    = out_c1_r;
    out_c2_nxt    = out_c2_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = fill_r[IDXW-1:0];
    ram_wdata     = in_tdata[7:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          loc_nxt     = in_tdata[31:16];
          hi_byte_nxt = in_tdata[15:8];
          idx_nxt     = '0;
          unique case (in_mode)
            MODE_DATA: begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + 1'b1;
              sum_nxt  = sum_r + in_tdata[7:0];
              if (fill_nxt == FULL) begin
                next_addr_nxt = in_tdata[31:16] + 16'd1;
                hi_pend_nxt   = in_tuser[2];
                is_end_nxt    = 1'b0;
                state_nxt     = ST_HEAD;
              end else if (in_tuser[2]) begin
                state_nxt = ST_BYTE2;
              end
            end
            MODE_ORIGIN: begin
              next_addr_nxt = in_tdata[31:16];
              hi_pend_nxt   = 1'b0;
              is_end_nxt    = 1'b0;
              state_nxt     = ST_HEAD;
            end
            MODE_END: begin
              hi_pend_nxt = 1'b0;
              is_end_nxt  = 1'b1;
              state_nxt   = ST_HEAD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // High byte of a word item
      ST_BYTE2: begin
        ram_we    = 1'b1;
        ram_wdata = hi_byte_r;
        fill_nxt  = fill_r + 1'b1;
        sum_nxt   = sum_r + hi_byte_r;
        idx_nxt   = '0;
        if (fill_nxt == FULL) begin
          next_addr_nxt = loc_r + 16'd2;
          hi_pend_nxt   = 1'b0;
          is_end_nxt    = 1'b0;
          state_nxt     = ST_HEAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_HEAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_c1_nxt    = CH_S;
          out_c2_nxt    = is_end_r ? CH_9 : CH_1;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_LEN;
        end
      end

      ST_LEN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_c1_nxt    = hex_char(len_byte[7:4]);
          out_c2_nxt    = hex_char(len_byte[3:0]);
          out_last_nxt  = 1'b0;
          state_nxt     = ST_AHI;
        end
      end

      ST_AHI: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_c1_nxt    = hex_char(hdr_addr[15:12]);
          out_c2_nxt    = hex_char(hdr_addr[11:8]);
          out_last_nxt  = 1'b0;
          state_nxt     = ST_ALO;
        end
      end

      ST_ALO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_c1_nxt    = hex_char(hdr_addr[7:4]);
          out_c2_nxt    = hex_char(hdr_addr[3:0]);
          out_last_nxt  = 1'b0;
          state_nxt     = (is_end_r || fill_r == '0) ? ST_SUM : ST_DATA;
        end
      end

      // RAM address follows idx_nxt, so ram_rdata holds entry idx_r here
      ST_DATA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_c1_nxt    = hex_char(ram_rdata[7:4]);
          out_c2_nxt    = hex_char(ram_rdata[3:0]);
          out_last_nxt  = 1'b0;
          if (FILLW'(idx_r) + 1'b1 == fill_r) begin
            state_nxt = ST_SUM;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      // Checksum pair ends the record; an S1 record restarts the buffer
      ST_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_c1_nxt    = hex_char(chk_sum[7:4]);
          out_c2_nxt    = hex_char(chk_sum[3:0]);
          out_last_nxt  = 1'b1;
          idx_nxt       = '0;
          if (is_end_r) begin
            state_nxt = ST_IDLE;
          end else begin
            fill_nxt  = '0;
            addr_nxt  = next_addr_r;
            sum_nxt   = next_addr_r[15:8] + next_addr_r[7:0];
            state_nxt = hi_pend_r ? ST_BYTE2 : ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      sum_r       <= '0;
      addr_r      <= '0;
      hi_pend_r   <= 1'b0;
      is_end_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      addr_r      <= addr_nxt;
      hi_pend_r   <= hi_pend_nxt;
      is_end_r    <= is_end_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    loc_r       <= loc_nxt;
    next_addr_r <= next_addr_nxt;
    hi_byte_r   <= hi_byte_nxt;
    out_c1_r    <= out_c1_nxt;
    out_c2_r    <= out_c2_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_c2_r, out_c1_r};
  assign out_tlast  = out_last_r;

endmodule
